### hw/rtl/g2c_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// g2c_pkg
// Shared types, constants and the signed Q30 product for the geodetic to
// cartesian conversion.
// ---------------------------------------------------------------------------
package g2c_pkg;

   localparam int unsigned ANGLE_ITERATIONS_DEF = 24;
   localparam int unsigned RSQRT_ITERATIONS     = 4;

   localparam logic [30:0] Q30_ONE       = 31'h4000_0000;
   localparam logic [31:0] Q30_THREE     = 32'hC000_0000;
   localparam logic [28:0] DEG_UNIT      = 29'd1048576;
   localparam logic [28:0] QUARTER_TURN  = 29'd94371840;    // 90 deg
   localparam logic [28:0] EIGHTH_TURN   = 29'd47185920;    // 45 deg
   localparam logic [28:0] ANGLE_OFFSET  = 29'd235929600;   // 225 deg
   localparam logic signed [27:0] LAT_MAX = 28'sd94371840;
   localparam logic signed [28:0] LON_MAX = 29'sd188743680;
   localparam logic signed [24:0] ALT_MIN = -25'sd256000;
   localparam logic signed [24:0] ALT_MAX = 25'sd12800000;
   localparam logic [36:0] RAD_PER_DEG_Q42 = 37'd76760392275;
   localparam logic [30:0] EQ_RADIUS_Q8    = 31'd1632803072;
   localparam logic [30:0] ONE_MINUS_F_SQ  = 31'd1066553788;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // series state of one angle
   typedef struct packed {
      logic [30:0]        x2;
      logic [30:0]        ts;
      logic [30:0]        tc;
      logic signed [31:0] s;
      logic signed [31:0] c;
   } g2c_ang_type;

   // what travels alongside the series
   typedef struct packed {
      logic signed [24:0] alt;
      logic [1:0]         lat_quad;
      logic               lat_neg;
      logic [1:0]         lon_quad;
      logic               lon_neg;
   } g2c_side_type;

   typedef struct packed {
      logic signed [31:0] sl;
      logic signed [31:0] cl;
      logic signed [31:0] so;
      logic signed [31:0] co;
      logic signed [24:0] alt;
   } g2c_trig_type;

   // a * b / 2^30, rounded to nearest, ties away from zero
   function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
      logic        neg;
      logic [32:0] ua;
      logic [32:0] ub;
      logic [65:0] p;
      logic [33:0] r;
      neg = a[33] ^ b[33];
      ua  = a[33] ? 33'(-a) : 33'(a);
      ub  = b[33] ? 33'(-b) : 33'(b);
      p   = 66'(ua) * 66'(ub) + 66'(32'h2000_0000);
      r   = p[63:30];
      return neg ? -$signed(r) : $signed(r);
   endfunction

endpackage
`default_nettype wire

### hw/rtl/g2c_sincos_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// g2c_sincos_cell
// One Taylor term for sine and cosine of both angles, three stages.
// ---------------------------------------------------------------------------
module g2c_sincos_cell #(
   parameter int unsigned K = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  g2c_pkg::g2c_ang_type [1:0]    in_ang,
   input  g2c_pkg::g2c_side_type         in_side,
   output logic                          out_valid,
   output g2c_pkg::g2c_ang_type [1:0]    out_ang,
   output g2c_pkg::g2c_side_type         out_side
);
   import g2c_pkg::*;

   localparam int unsigned MS = 2 * K * (2 * K + 1);
   localparam int unsigned MC = (2 * K - 1) * (2 * K);
   localparam logic [31:0] RS = 32'((64'd1 << 32) / MS);
   localparam logic [31:0] RC = 32'((64'd1 << 32) / MC);

   g2c_ang_type [1:0] a_ang_ff, a_ang_in;
   g2c_ang_type [1:0] b_ang_ff;
   logic [1:0][30:0]  b_qs_ff, b_qs_in, b_qc_ff, b_qc_in;
   g2c_ang_type [1:0] c_ang_ff, c_ang_in;
   g2c_side_type      a_side_ff, b_side_ff, c_side_ff;
   logic              a_valid_ff, b_valid_ff, c_valid_ff;

   // stage A: term times x^2
   always_comb begin
      logic [61:0] ps;
      logic [61:0] pc;
      for (int i = 0; i < 2; i++) begin
         ps = 62'(in_ang[i].ts) * 62'(in_ang[i].x2);
         pc = 62'(in_ang[i].tc) * 62'(in_ang[i].x2);
         a_ang_in[i]    = in_ang[i];
         a_ang_in[i].ts = ps[60:30];
         a_ang_in[i].tc = pc[60:30];
      end
   end

   // stage B: reciprocal estimate of the quotient, low by at most one
   always_comb begin
      logic [62:0] qs;
      logic [62:0] qc;
      for (int i = 0; i < 2; i++) begin
         qs = 63'(a_ang_ff[i].ts) * 63'(RS);
         qc = 63'(a_ang_ff[i].tc) * 63'(RC);
         b_qs_in[i] = qs[62:32];
         b_qc_in[i] = qc[62:32];
      end
   end

   // stage C: correct quotient and accumulate
   always_comb begin
      logic [43:0] rs;
      logic [43:0] rc;
      logic [30:0] qs;
      logic [30:0] qc;
      for (int i = 0; i < 2; i++) begin
         rs = 44'(b_ang_ff[i].ts) - 44'(b_qs_ff[i]) * 44'(MS);
         rc = 44'(b_ang_ff[i].tc) - 44'(b_qc_ff[i]) * 44'(MC);
         qs = (rs >= 44'(MS)) ? b_qs_ff[i] + 31'd1 : b_qs_ff[i];
         qc = (rc >= 44'(MC)) ? b_qc_ff[i] + 31'd1 : b_qc_ff[i];
         c_ang_in[i]    = b_ang_ff[i];
         c_ang_in[i].ts = qs;
         c_ang_in[i].tc = qc;
         if (K % 2 == 1) begin
            c_ang_in[i].s = b_ang_ff[i].s - $signed(32'(qs));
            c_ang_in[i].c = b_ang_ff[i].c - $signed(32'(qc));
         end else begin
            c_ang_in[i].s = b_ang_ff[i].s + $signed(32'(qs));
            c_ang_in[i].c = b_ang_ff[i].c + $signed(32'(qc));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ang_ff  <= a_ang_in;
         a_side_ff <= in_side;
         b_ang_ff  <= a_ang_ff;
         b_qs_ff   <= b_qs_in;
         b_qc_ff   <= b_qc_in;
         b_side_ff <= a_side_ff;
         c_ang_ff  <= c_ang_in;
         c_side_ff <= b_side_ff;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_ang   = c_ang_ff;
   assign out_side  = c_side_ff;

endmodule
`default_nettype wire

### hw/rtl/g2c_rsqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// g2c_rsqrt_cell
// One Newton step of the inverse square root, three stages.
// ---------------------------------------------------------------------------
module g2c_rsqrt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [31:0]           in_d,
   input  logic [31:0]           in_y,
   input  g2c_pkg::g2c_trig_type in_trig,
   output logic                  out_valid,
   output logic [31:0]           out_d,
   output logic [31:0]           out_y,
   output g2c_pkg::g2c_trig_type out_trig
);
   import g2c_pkg::*;

   logic [31:0]  a_y2_ff, a_y2_in, a_y_ff, a_d_ff;
   logic [31:0]  b_f_ff, b_f_in, b_y_ff, b_d_ff;
   logic [31:0]  c_y_ff, c_y_in, c_d_ff;
   g2c_trig_type a_trig_ff, b_trig_ff, c_trig_ff;
   logic         a_valid_ff, b_valid_ff, c_valid_ff;
   logic [63:0]  p_a, p_b, p_c;
   logic [31:0]  t_b;

   assign p_a     = 64'(in_y) * 64'(in_y);
   assign a_y2_in = p_a[61:30];

   assign p_b    = 64'(a_d_ff) * 64'(a_y2_ff);
   assign t_b    = p_b[61:30];
   assign b_f_in = (Q30_THREE > t_b) ? Q30_THREE - t_b : 32'd0;

   assign p_c    = 64'(b_y_ff) * 64'(b_f_ff);
   assign c_y_in = p_c[62:31];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_y2_ff   <= a_y2_in;
         a_y_ff    <= in_y;
         a_d_ff    <= in_d;
         a_trig_ff <= in_trig;
         b_f_ff    <= b_f_in;
         b_y_ff    <= a_y_ff;
         b_d_ff    <= a_d_ff;
         b_trig_ff <= a_trig_ff;
         c_y_ff    <= c_y_in;
         c_d_ff    <= b_d_ff;
         c_trig_ff <= b_trig_ff;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_d     = c_d_ff;
   assign out_y     = c_y_ff;
   assign out_trig  = c_trig_ff;

endmodule
`default_nettype wire

### hw/rtl/geodetic_to_cartesian.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// geodetic_to_cartesian
// Geodetic latitude, longitude and altitude to Earth-centred x, y, z.
// ---------------------------------------------------------------------------
// Usage
//   req_*: one geodetic point per transaction (valid/stall). Angles are
//   signed degrees * 2^20, altitude signed metres * 2^8; out-of-range
//   values are clamped. rsp_*: x, y, z in signed metres * 2^8.
//   The row of Taylor cells (three stages each) and the four Newton cells
//   of the inverse square root make up most of the pipeline. Throughput:
//   one transaction per cycle while the pipeline is not held.
//   The whole pipeline moves on one enable; it holds only while a result
//   sits in the output register and rsp_stall is high, and req_stall is
//   raised for exactly those cycles. The held result does not change.
//   Reset (synchronous) empties every stage; there is no other state and
//   no clearing pass.
// ---------------------------------------------------------------------------
module geodetic_to_cartesian #(
   parameter int unsigned ANGLE_ITERATIONS = g2c_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [27:0] req_latitude_deg,
   input  logic signed [28:0] req_longitude_deg,
   input  logic signed [24:0] req_altitude_m,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_x_m,
   output logic signed [31:0] rsp_y_m,
   output logic signed [31:0] rsp_z_m
);
   import g2c_pkg::*;

   localparam int unsigned N = ANGLE_ITERATIONS;

   logic en;

   // quadrant reduction: t = d + 225 deg, k = t / 90 deg, r = rest - 45 deg
   function automatic logic [29:0] reduce(input logic signed [28:0] d);
      logic [28:0]        t;
      logic [1:0]         q;
      logic [28:0]        base;
      logic signed [26:0] r;
      t = 29'(d) + ANGLE_OFFSET;
      if (t >= 29'(4 * QUARTER_TURN)) begin
         q = QUAD_2;
         base = 29'(4 * QUARTER_TURN);
      end else if (t >= 29'(3 * QUARTER_TURN)) begin
         q = QUAD_1;
         base = 29'(3 * QUARTER_TURN);
      end else if (t >= 29'(2 * QUARTER_TURN)) begin
         q = QUAD_0;
         base = 29'(2 * QUARTER_TURN);
      end else if (t >= QUARTER_TURN) begin
         q = QUAD_3;
         base = QUARTER_TURN;
      end else begin
         q = QUAD_2;
         base = 29'd0;
      end
      r = 27'($signed(t - base - EIGHTH_TURN));
      return {q, 1'b0, r};
   endfunction

   // ---- stage P0: clamp and reduce ------------------------------------
   logic signed [27:0] lat_c;
   logic signed [28:0] lon_c;
   logic signed [24:0] alt_c;
   logic [29:0]        red_lat, red_lon;
   logic signed [26:0] p0_rlat_ff, p0_rlon_ff;
   g2c_side_type       p0_side_ff, p0_side_in;
   logic               p0_valid_ff;

   always_comb begin
      lat_c = (req_latitude_deg > LAT_MAX) ? LAT_MAX :
              (req_latitude_deg < -LAT_MAX) ? -LAT_MAX : req_latitude_deg;
      lon_c = (req_longitude_deg > LON_MAX) ? LON_MAX :
              (req_longitude_deg < -LON_MAX) ? -LON_MAX : req_longitude_deg;
      alt_c = (req_altitude_m > ALT_MAX) ? ALT_MAX :
              (req_altitude_m < ALT_MIN) ? ALT_MIN : req_altitude_m;
      red_lat = reduce(29'(lat_c));
      red_lon = reduce(lon_c);
      p0_side_in.alt      = alt_c;
      p0_side_in.lat_quad = red_lat[29:28];
      p0_side_in.lat_neg  = red_lat[26];
      p0_side_in.lon_quad = red_lon[29:28];
      p0_side_in.lon_neg  = red_lon[26];
   end

   // ---- stage P1: degrees to Q30 radians ------------------------------
   logic [30:0]  p1_xlat_ff, p1_xlon_ff, p1_xlat_in, p1_xlon_in;
   g2c_side_type p1_side_ff;
   logic         p1_valid_ff;

   always_comb begin
      logic [25:0] mlat;
      logic [25:0] mlon;
      logic [63:0] plat;
      logic [63:0] plon;
      mlat = p0_rlat_ff[26] ? 26'(-p0_rlat_ff) : 26'(p0_rlat_ff);
      mlon = p0_rlon_ff[26] ? 26'(-p0_rlon_ff) : 26'(p0_rlon_ff);
      plat = 64'(mlat) * 64'(RAD_PER_DEG_Q42) + 64'h8000_0000;
      plon = 64'(mlon) * 64'(RAD_PER_DEG_Q42) + 64'h8000_0000;
      p1_xlat_in = plat[62:32];
      p1_xlon_in = plon[62:32];
   end

   // ---- stage P2: x^2 and series start --------------------------------
   g2c_ang_type [1:0] p2_ang_ff, p2_ang_in;
   g2c_side_type      p2_side_ff;
   logic              p2_valid_ff;

   always_comb begin
      logic [61:0] sq;
      logic [30:0] xv;
      for (int i = 0; i < 2; i++) begin
         xv = (i == 0) ? p1_xlat_ff : p1_xlon_ff;
         sq = 62'(xv) * 62'(xv) + 62'(32'h2000_0000);
         p2_ang_in[i].x2 = sq[60:30];
         p2_ang_in[i].ts = xv;
         p2_ang_in[i].tc = Q30_ONE;
         p2_ang_in[i].s  = $signed(32'(xv));
         p2_ang_in[i].c  = $signed(32'(Q30_ONE));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p0_valid_ff <= req_valid;
         p1_valid_ff <= p0_valid_ff;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_rlat_ff <= $signed(red_lat[26:0]);
         p0_rlon_ff <= $signed(red_lon[26:0]);
         p0_side_ff <= p0_side_in;
         p1_xlat_ff <= p1_xlat_in;
         p1_xlon_ff <= p1_xlon_in;
         p1_side_ff <= p0_side_ff;
         p2_ang_ff  <= p2_ang_in;
         p2_side_ff <= p1_side_ff;
      end
   end

   // ---- row of Taylor cells ------------------------------------------
   g2c_ang_type [1:0] ch_ang  [0:N];
   g2c_side_type      ch_side [0:N];
   logic [N:0]        ch_valid;

   assign ch_ang[0]   = p2_ang_ff;
   assign ch_side[0]  = p2_side_ff;
   assign ch_valid[0] = p2_valid_ff;

   for (genvar g = 0; g < N; g++) begin : g_term
      g2c_sincos_cell #(.K(g + 1)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (ch_valid[g]),
         .in_ang    (ch_ang[g]),
         .in_side   (ch_side[g]),
         .out_valid (ch_valid[g+1]),
         .out_ang   (ch_ang[g+1]),
         .out_side  (ch_side[g+1])
      );
   end

   // ---- stage T0: signs and quadrant map --------------------------------
   g2c_trig_type t0_trig_ff, t0_trig_in;
   logic         t0_valid_ff;

   always_comb begin
      logic signed [31:0] s0;
      logic signed [31:0] c0;
      logic signed [31:0] s1;
      logic signed [31:0] c1;
      s0 = ch_side[N].lat_neg ? -ch_ang[N][0].s : ch_ang[N][0].s;
      c0 = ch_ang[N][0].c;
      s1 = ch_side[N].lon_neg ? -ch_ang[N][1].s : ch_ang[N][1].s;
      c1 = ch_ang[N][1].c;
      t0_trig_in.alt = ch_side[N].alt;
      unique case (ch_side[N].lat_quad)
         QUAD_0: begin t0_trig_in.sl = s0;  t0_trig_in.cl = c0;  end
         QUAD_1: begin t0_trig_in.sl = c0;  t0_trig_in.cl = -s0; end
         QUAD_2: begin t0_trig_in.sl = -s0; t0_trig_in.cl = -c0; end
         default: begin t0_trig_in.sl = -c0; t0_trig_in.cl = s0; end
      endcase
      unique case (ch_side[N].lon_quad)
         QUAD_0: begin t0_trig_in.so = s1;  t0_trig_in.co = c1;  end
         QUAD_1: begin t0_trig_in.so = c1;  t0_trig_in.co = -s1; end
         QUAD_2: begin t0_trig_in.so = -s1; t0_trig_in.co = -c1; end
         default: begin t0_trig_in.so = -c1; t0_trig_in.co = s1; end
      endcase
   end

   // ---- stages D1, D2: D = cos^2 + (1-f)^2 sin^2 -----------------------
   logic [61:0]  d1_uc2_ff, d1_uc2_in;
   logic [30:0]  d1_us2_ff, d1_us2_in;
   g2c_trig_type d1_trig_ff, d2_trig_ff;
   logic [31:0]  d2_d_ff, d2_d_in;
   logic         d1_valid_ff, d2_valid_ff;

   always_comb begin
      logic [30:0] us;
      logic [30:0] uc;
      logic [61:0] ps;
      us = t0_trig_ff.sl[31] ? 31'(-t0_trig_ff.sl) : 31'(t0_trig_ff.sl);
      uc = t0_trig_ff.cl[31] ? 31'(-t0_trig_ff.cl) : 31'(t0_trig_ff.cl);
      ps = 62'(us) * 62'(us);
      d1_us2_in = ps[60:30];
      d1_uc2_in = 62'(uc) * 62'(uc);
   end

   always_comb begin
      logic [62:0] sum;
      sum = 63'(d1_uc2_ff) + 63'(d1_us2_ff) * 63'(ONE_MINUS_F_SQ);
      d2_d_in = sum[61:30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_valid_ff <= 1'b0;
         d1_valid_ff <= 1'b0;
         d2_valid_ff <= 1'b0;
      end else if (en) begin
         t0_valid_ff <= ch_valid[N];
         d1_valid_ff <= t0_valid_ff;
         d2_valid_ff <= d1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t0_trig_ff <= t0_trig_in;
         d1_uc2_ff  <= d1_uc2_in;
         d1_us2_ff  <= d1_us2_in;
         d1_trig_ff <= t0_trig_ff;
         d2_d_ff    <= d2_d_in;
         d2_trig_ff <= d1_trig_ff;
      end
   end

   // ---- Newton cells for 1/sqrt(D) --------------------------------------
   logic [31:0]  nw_d    [0:RSQRT_ITERATIONS];
   logic [31:0]  nw_y    [0:RSQRT_ITERATIONS];
   g2c_trig_type nw_trig [0:RSQRT_ITERATIONS];
   logic [RSQRT_ITERATIONS:0] nw_valid;

   assign nw_d[0]     = d2_d_ff;
   assign nw_y[0]     = 32'(Q30_ONE);
   assign nw_trig[0]  = d2_trig_ff;
   assign nw_valid[0] = d2_valid_ff;

   for (genvar g = 0; g < RSQRT_ITERATIONS; g++) begin : g_newton
      g2c_rsqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (nw_valid[g]),
         .in_d      (nw_d[g]),
         .in_y      (nw_y[g]),
         .in_trig   (nw_trig[g]),
         .out_valid (nw_valid[g+1]),
         .out_d     (nw_d[g+1]),
         .out_y     (nw_y[g+1]),
         .out_trig  (nw_trig[g+1])
      );
   end

   // ---- stages M1..M4: radii and final products ------------------------
   localparam int unsigned NL = RSQRT_ITERATIONS;

   logic signed [33:0] m1_n_ff, m2_n_ff, m2_ns_ff, m3_t1_ff, m3_zs_ff;
   g2c_trig_type       m1_trig_ff, m2_trig_ff, m3_trig_ff;
   logic               m1_valid_ff, m2_valid_ff, m3_valid_ff, m4_valid_ff;
   logic signed [31:0] m4_x_ff, m4_y_ff, m4_z_ff;
   logic signed [33:0] m4_x_in, m4_y_in, m4_z_in;
   logic signed [33:0] m1_n_in, m2_ns_in, m3_t1_in, m3_zs_in;

   assign m1_n_in  = mul_q30($signed(34'(EQ_RADIUS_Q8)), $signed(34'(nw_y[NL])));
   assign m2_ns_in = mul_q30(m1_n_ff, $signed(34'(ONE_MINUS_F_SQ)));
   assign m3_t1_in = mul_q30(m2_n_ff + 34'(m2_trig_ff.alt), 34'(m2_trig_ff.cl));
   assign m3_zs_in = m2_ns_ff + 34'(m2_trig_ff.alt);
   assign m4_x_in  = mul_q30(m3_t1_ff, 34'(m3_trig_ff.co));
   assign m4_y_in  = mul_q30(m3_t1_ff, 34'(m3_trig_ff.so));
   assign m4_z_in  = mul_q30(m3_zs_ff, 34'(m3_trig_ff.sl));

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
         m4_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= nw_valid[NL];
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
         m4_valid_ff <= m3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_n_ff    <= m1_n_in;
         m1_trig_ff <= nw_trig[NL];
         m2_n_ff    <= m1_n_ff;
         m2_ns_ff   <= m2_ns_in;
         m2_trig_ff <= m1_trig_ff;
         m3_t1_ff   <= m3_t1_in;
         m3_zs_ff   <= m3_zs_in;
         m3_trig_ff <= m2_trig_ff;
         m4_x_ff    <= m4_x_in[31:0];
         m4_y_ff    <= m4_y_in[31:0];
         m4_z_ff    <= m4_z_in[31:0];
      end
   end

   // pipeline moves unless the output register is full and held
   assign en        = !(m4_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = m4_valid_ff;
   assign rsp_x_m   = m4_x_ff;
   assign rsp_y_m   = m4_y_ff;
   assign rsp_z_m   = m4_z_ff;

endmodule
`default_nettype wire

### hw/rtl/g2c_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// g2c_checker
// Port-level checks on the conversion pipeline, bound to the top level.
// ---------------------------------------------------------------------------
module g2c_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_x_m,
   input logic signed [31:0] rsp_y_m,
   input logic signed [31:0] rsp_z_m
);

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input is held back only while a result is held at the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output stall");

   a_stall_prop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while output held");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_x_m)
                                    && $stable(rsp_y_m) && $stable(rsp_z_m)))
      else $error("held result changed");

endmodule

bind geodetic_to_cartesian g2c_checker u_g2c_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_x_m   (rsp_x_m),
   .rsp_y_m   (rsp_y_m),
   .rsp_z_m   (rsp_z_m)
);
`default_nettype wire

### bench/geodetic_to_cartesian_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// geodetic_to_cartesian_test
// Streams geodetic points through the converter, predicts x, y, z per point
// in 64-bit integer arithmetic and compares each transaction in order.
// ---------------------------------------------------------------------------

class ecef_scoreboard;
   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } ecef_point_type;

   ecef_point_type pending[$];
   int             errors;

   // rounded Q30 product, ties away from zero
   static function longint mulq(longint a, longint b);
      bit       neg;
      longint   ua;
      longint   ub;
      longint   p;
      neg = (a < 0) != (b < 0);
      ua  = a < 0 ? -a : a;
      ub  = b < 0 ? -b : b;
      p   = (ua * ub + 64'sd536870912) >>> 30;
      return neg ? -p : p;
   endfunction

   static function void series(longint x, output longint sn, output longint cs);
      longint x2;
      longint ts;
      longint tc;
      longint k;
      x2 = (x * x + 64'sd536870912) >>> 30;
      ts = x;
      tc = 64'sd1073741824;
      sn = x;
      cs = tc;
      for (k = 1; k <= 24; k++) begin
         ts = ((ts * x2) >>> 30) / ((2 * k) * (2 * k + 1));
         tc = ((tc * x2) >>> 30) / ((2 * k - 1) * (2 * k));
         if (k % 2 == 1) begin
            sn -= ts;
            cs -= tc;
         end else begin
            sn += ts;
            cs += tc;
         end
      end
   endfunction

   // exact octant reduction in degrees * 2^20
   static function void trig_deg(longint d, output longint sn, output longint cs);
      longint t;
      longint q;
      longint r;
      longint mag;
      longint x;
      longint s;
      longint c;
      t   = d + 225 * 1048576;
      q   = t / (90 * 1048576);
      r   = t - q * (90 * 1048576) - 45 * 1048576;
      mag = r < 0 ? -r : r;
      x   = longint'((mag * 64'd76760392275 + 64'd2147483648) >> 32);
      series(x, s, c);
      if (r < 0) s = -s;
      case ((q + 2) % 4)
         0: begin sn = s;  cs = c;  end
         1: begin sn = c;  cs = -s; end
         2: begin sn = -s; cs = -c; end
         default: begin sn = -c; cs = s; end
      endcase
   endfunction

   // one line per mismatch, counted
   task report(string msg);
      $display("%s", msg);
      errors++;
   endtask

   function void note_point(logic signed [27:0] lat_i, logic signed [28:0] lon_i,
                            logic signed [24:0] alt_i);
      longint         lat;
      longint         lon;
      longint         h;
      longint         sl;
      longint         cl;
      longint         so;
      longint         co;
      longint         us;
      longint         uc;
      longint         d;
      longint         y;
      longint         y2;
      longint         t;
      longint         f;
      longint         n;
      longint         ns;
      longint         t1;
      ecef_point_type e;
      lat = lat_i;
      lon = lon_i;
      h   = alt_i;
      if (lat > 94371840) lat = 94371840;
      if (lat < -94371840) lat = -94371840;
      if (lon > 188743680) lon = 188743680;
      if (lon < -188743680) lon = -188743680;
      if (h > 12800000) h = 12800000;
      if (h < -256000) h = -256000;
      trig_deg(lat, sl, cl);
      trig_deg(lon, so, co);
      us = sl < 0 ? -sl : sl;
      uc = cl < 0 ? -cl : cl;
      d  = longint'((64'(uc) * 64'(uc) + ((64'(us) * 64'(us)) >> 30) * 64'd1066553788) >> 30);
      y  = 64'sd1073741824;
      repeat (4) begin
         y2 = (y * y) >>> 30;
         t  = longint'((64'(d) * 64'(y2)) >> 30);
         f  = (3 * 64'sd1073741824 > t) ? 3 * 64'sd1073741824 - t : 0;
         y  = longint'((64'(y) * 64'(f)) >> 31);
      end
      n   = mulq(64'sd1632803072, y);
      ns  = mulq(n, 64'sd1066553788);
      t1  = mulq(n + h, cl);
      e.x = 32'(mulq(t1, co));
      e.y = 32'(mulq(t1, so));
      e.z = 32'(mulq(ns + h, sl));
      pending.push_back(e);
   endfunction

   task check_point(logic signed [31:0] x, logic signed [31:0] y,
                    logic signed [31:0] z);
      ecef_point_type e;
      if (pending.size() == 0) begin
         report($sformatf("unexpected transaction x=%0d y=%0d z=%0d", x, y, z));
         return;
      end
      e = pending.pop_front();
      if (x !== e.x)
         report($sformatf("x mismatch: got %0d want %0d", x, e.x));
      if (y !== e.y)
         report($sformatf("y mismatch: got %0d want %0d", y, e.y));
      if (z !== e.z)
         report($sformatf("z mismatch: got %0d want %0d", z, e.z));
   endtask
endclass

module geodetic_to_cartesian_test;
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [27:0] req_latitude_deg = '0;
   logic signed [28:0] req_longitude_deg = '0;
   logic signed [24:0] req_altitude_m = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_x_m;
   logic signed [31:0] rsp_y_m;
   logic signed [31:0] rsp_z_m;

   ecef_scoreboard track = new();
   bit             hold_rsp;   // long receiver hold-off requested
   bit             sending_done;

   always #5 clock = ~clock;

   geodetic_to_cartesian u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_latitude_deg  (req_latitude_deg),
      .req_longitude_deg (req_longitude_deg),
      .req_altitude_m    (req_altitude_m),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_x_m           (rsp_x_m),
      .rsp_y_m           (rsp_y_m),
      .rsp_z_m           (rsp_z_m)
   );

   // mostly short gaps, the odd long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // one transaction on the request side; sampled at the edge it is taken
   task automatic send_point(logic signed [27:0] la, logic signed [28:0] lo,
                             logic signed [24:0] al);
      int g;
      g = gap_len();
      if (($urandom_range(0, 2) == 0) && g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_latitude_deg  <= la;
      req_longitude_deg <= lo;
      req_altitude_m    <= al;
      do @(posedge clock); while (req_stall);
      track.note_point(la, lo, al);
   endtask

   // random point: mostly in range, the rest raw bits, often beyond the clamps
   task automatic send_random();
      int mode;
      mode = $urandom_range(0, 9);
      if (mode < 7)
         send_point(28'($signed($urandom_range(0, 188743680)) - 94371840),
                    29'($signed($urandom_range(0, 377487360)) - 188743680),
                    25'($signed($urandom_range(0, 13056000)) - 256000));
      else
         send_point(28'($urandom), 29'($urandom), 25'($urandom));
   endtask

   // receiver: random stalls, plus a long counted hold when asked
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         track.check_point(rsp_x_m, rsp_y_m, rsp_z_m);
   end

   initial begin : receiver
      int n;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            n = 0;
            while (n < 300) begin
               @(posedge clock);
               n++;
            end
            hold_rsp = 1'b0;
         end
         n = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
         rsp_stall <= (n > 0);
         if (n > 0) repeat (n) @(posedge clock);
         else @(posedge clock);
         // runs with no stall at all
         if ($urandom_range(0, 30) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(50, 200)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int i;
      int w;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: equator, poles, antimeridian, clamps, bit extremes
      send_point('0, '0, '0);
      send_point(28'sd94371840, '0, '0);
      send_point(-28'sd94371840, '0, '0);
      send_point('0, 29'sd188743680, '0);
      send_point('0, -29'sd188743680, '0);
      send_point('0, 29'sd94371840, '0);
      send_point('0, -29'sd94371840, '0);
      send_point(28'sd47185920, 29'sd47185920, 25'sd100000);
      send_point(28'h7ff_ffff, 29'h0fff_ffff, 25'h0ff_ffff);
      send_point(28'h800_0000, 29'h1000_0000, 25'h100_0000);
      send_point(28'sd94371841, 29'sd188743681, 25'sd12800001);
      send_point(-28'sd94371841, -29'sd188743681, -25'sd256001);
      send_point('0, '0, 25'sd12800000);
      send_point('0, '0, -25'sd256000);
      send_point(28'hfff_ffff, 29'h1fff_ffff, 25'h1ff_ffff);
      send_point(28'sd1, -29'sd1, 25'sd1);
      send_point(-28'sd47185920, 29'sd141557760, -25'sd1);

      for (i = 0; i < 1550; i++) begin
         if (i == 400) hold_rsp = 1'b1;   // block fills and stalls its input
         if (i == 900) begin
            // sender waits for the pipeline to drain
            req_valid <= 1'b0;
            w = 0;
            while (track.pending.size() != 0 && w < 20000) begin
               @(posedge clock);
               w++;
            end
         end
         send_random();
      end
      req_valid <= 1'b0;
      sending_done = 1'b1;
   end

   initial begin : finish_run
      int w;
      wait (sending_done);
      w = 0;
      while (track.pending.size() != 0 && w < 100000) begin
         @(posedge clock);
         w++;
      end
      repeat (200) @(posedge clock);
      if (track.errors == 0 && track.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
